[design/cvfd_pkg.sv]
// Shared types, constants and helper functions for the CI-V response frame decoder.
// Used by every module of the decoder; depends on nothing else.
package cvfd_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 2047;
  localparam int HEAD_DEPTH = 11;
  localparam int TAIL_KEEP = 3;
  localparam int LEAD_PAIRS = 5;

  localparam int PAIR_W = 8;
  localparam int LO_W = 21;
  localparam int HI_W = 15;
  localparam int TBL_W = 19;
  localparam int HZ_W = 34;
  localparam int LVL_W = 9;

  localparam logic [7:0] RADIO_ADDR_RST = 8'hA4;
  localparam logic [7:0] PC_ADDR_RST = 8'hE0;

  localparam logic [7:0] CMD_ACK = 8'hFB;
  localparam logic [7:0] CMD_NG = 8'hFA;
  localparam logic [7:0] CMD_FREQ = 8'h03;
  localparam logic [7:0] CMD_SCOPE = 8'h27;
  localparam logic [7:0] SUB_SPAN = 8'h15;
  localparam logic [7:0] SUB_REF = 8'h19;

  localparam logic [HZ_W-1:0] SPAN_RST = 34'd5000;

  localparam logic REG_RADIO_ADDR = 1'b0;
  localparam logic REG_PC_ADDR = 1'b1;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_ACK = 3'd0;
  localparam kind_t KIND_NG = 3'd1;
  localparam kind_t KIND_FREQ = 3'd2;
  localparam kind_t KIND_SPAN = 3'd3;
  localparam kind_t KIND_REF = 3'd4;
  localparam kind_t KIND_IGNORE = 3'd5;

  typedef struct packed {
    logic [HEAD_DEPTH-1:0][7:0] head;
    logic [TAIL_KEEP-1:0][7:0]  tail;
    logic                       short_frame;
    logic [LEAD_PAIRS-1:0]      len_ge8;
    logic                       len_ge13;
  } snap_t;

  typedef struct packed {
    kind_t                          kind;
    logic [LEAD_PAIRS-1:0][PAIR_W-1:0] fpair;
    logic [TAIL_KEEP-1:0][PAIR_W-1:0]  tpair;
    logic [LEAD_PAIRS-1:0][PAIR_W-1:0] lpair;
    logic [TBL_W-1:0]               tbl;
    logic                           tail_ok;
    logic signed [LVL_W-1:0]        ref_level;
  } dec_t;

  typedef struct packed {
    kind_t                   kind;
    logic [LO_W-1:0]         f_lo;
    logic [HI_W-1:0]         f_hi;
    logic [LO_W-1:0]         t_sum;
    logic [LO_W-1:0]         l_lo;
    logic [HI_W-1:0]         l_hi;
    logic [TBL_W-1:0]        tbl;
    logic                    tail_ok;
    logic signed [LVL_W-1:0] ref_level;
  } sum_t;

  typedef struct packed {
    kind_t                   kind;
    logic [HZ_W-1:0]         freq;
    logic [HZ_W-1:0]         lead;
    logic [LO_W-1:0]         t_sum;
    logic [TBL_W-1:0]        tbl;
    logic                    tail_ok;
    logic signed [LVL_W-1:0] ref_level;
  } res_t;

  // Two BCD digits of one byte, a non-decimal nibble taken at its binary value.
  function automatic logic [PAIR_W-1:0] bcd_pair(input logic [7:0] b);
    return PAIR_W'(b[7:4]) * PAIR_W'(10) + PAIR_W'(b[3:0]);
  endfunction

  // Three pairs, lowest weight first.
  function automatic logic [LO_W-1:0] sum3(input logic [PAIR_W-1:0] a,
                                           input logic [PAIR_W-1:0] b,
                                           input logic [PAIR_W-1:0] c);
    return LO_W'(a) + LO_W'(b) * LO_W'(100) + LO_W'(c) * LO_W'(10000);
  endfunction

  function automatic logic [HI_W-1:0] sum2(input logic [PAIR_W-1:0] a,
                                           input logic [PAIR_W-1:0] b);
    return HI_W'(a) + HI_W'(b) * HI_W'(100);
  endfunction

  // Span from the fixed BCD table first, then from the binary code table.
  function automatic logic [TBL_W-1:0] span_lookup(input logic [7:0] lo,
                                                   input logic [7:0] hi);
    logic [TBL_W-1:0] hz;
    hz = '0;
    case ({hi, lo})
      16'h0025: hz = TBL_W'(2500);
      16'h0050: hz = TBL_W'(5000);
      16'h0100: hz = TBL_W'(10000);
      16'h0250: hz = TBL_W'(25000);
      16'h0500: hz = TBL_W'(50000);
      16'h1000: hz = TBL_W'(100000);
      16'h2500: hz = TBL_W'(250000);
      16'h5000: hz = TBL_W'(500000);
      16'd2:    hz = TBL_W'(2500);
      16'd5:    hz = TBL_W'(5000);
      16'd10:   hz = TBL_W'(10000);
      16'd25:   hz = TBL_W'(25000);
      16'd50:   hz = TBL_W'(50000);
      16'd100:  hz = TBL_W'(100000);
      16'd250:  hz = TBL_W'(250000);
      16'd500:  hz = TBL_W'(500000);
      default:  hz = '0;
    endcase
    return hz;
  endfunction

endpackage

[design/cvfd_cfg.sv]
// Configuration registers of the frame decoder behind an APB-style port.
// Depends on cvfd_pkg for register indexes and reset values.
module cvfd_cfg import cvfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [7:0]  radio_addr,
  output logic [7:0]  pc_addr
);

  logic [7:0] radio_addr_r;
  logic [7:0] pc_addr_r;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radio_addr_r <= RADIO_ADDR_RST;
      pc_addr_r <= PC_ADDR_RST;
    end else if (wr_en) begin
      if (cfg_paddr[2] == REG_RADIO_ADDR) begin
        radio_addr_r <= cfg_pwdata[7:0];
      end else begin
        pc_addr_r <= cfg_pwdata[7:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_PC_ADDR) ? {24'd0, pc_addr_r} : {24'd0, radio_addr_r};
  assign radio_addr = radio_addr_r;
  assign pc_addr = pc_addr_r;

endmodule

[design/cvfd_capture.sv]
// Byte capture for the frame decoder: byte count, head bytes, recent bytes, and a
// snapshot register loaded on the last byte of a frame. Depends on cvfd_pkg.
module cvfd_capture import cvfd_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  output logic       snap_valid,
  input  logic       snap_ready,
  output snap_t      snap
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_inc;
  logic [HEAD_DEPTH-1:0][7:0] head_r;
  logic [HEAD_DEPTH-1:0][7:0] head_nxt;
  logic [TAIL_KEEP-1:0][7:0]  tail_r;
  logic                       snap_vld_r;
  snap_t                      snap_r;
  snap_t                      snap_nxt;
  logic                       accept;

  assign in_tready = !snap_vld_r || snap_ready;
  assign accept = in_tvalid && in_tready;

  always_comb begin
    count_inc = (count_r < CW'(MAX_FRAME_BYTES)) ? count_r + CW'(1) : count_r;
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      head_nxt[i] = (count_r == CW'(i)) ? in_tdata : head_r[i];
    end
    snap_nxt.head = head_nxt;
    snap_nxt.tail = tail_r;
    snap_nxt.short_frame = count_inc < CW'(5);
    for (int i = 0; i < LEAD_PAIRS; i++) begin
      snap_nxt.len_ge8[i] = count_inc >= CW'(8 + i);
    end
    snap_nxt.len_ge13 = count_inc >= CW'(13);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      snap_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= in_tlast ? '0 : count_inc;
      end
      if (accept && in_tlast) begin
        snap_vld_r <= 1'b1;
      end else if (snap_ready) begin
        snap_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_r <= head_nxt;
      tail_r <= {in_tdata, tail_r[TAIL_KEEP-1:1]};
    end
    if (accept && in_tlast) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = snap_vld_r;
  assign snap = snap_r;

endmodule

[design/cvfd_decode.sv]
// Three-stage frame decode: classification and BCD pairs, partial weighted sums,
// then full 34-bit sums. Depends on cvfd_pkg for types and helper functions.
module cvfd_decode import cvfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] radio_addr,
  input  logic [7:0] pc_addr,
  input  logic       snap_valid,
  output logic       snap_ready,
  input  snap_t      snap,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res
);

  logic  s2_vld_r, s3_vld_r, s4_vld_r;
  logic  s2_rdy, s3_rdy, s4_rdy;
  dec_t  s2_r, s2_nxt;
  sum_t  s3_r, s3_nxt;
  res_t  s4_r, s4_nxt;
  logic  from_radio;
  logic [PAIR_W-1:0] mag;

  assign s4_rdy = !s4_vld_r || res_ready;
  assign s3_rdy = !s3_vld_r || s4_rdy;
  assign s2_rdy = !s2_vld_r || s3_rdy;
  assign snap_ready = s2_rdy;

  always_comb begin
    from_radio = (snap.head[2] == pc_addr) && (snap.head[3] == radio_addr);
    s2_nxt.kind = KIND_IGNORE;
    if (snap.short_frame) begin
      s2_nxt.kind = KIND_IGNORE;
    end else if (snap.head[4] == CMD_ACK) begin
      s2_nxt.kind = KIND_ACK;
    end else if (snap.head[4] == CMD_NG) begin
      s2_nxt.kind = KIND_NG;
    end else if (snap.head[4] == CMD_FREQ && snap.len_ge8[3] && from_radio) begin
      s2_nxt.kind = KIND_FREQ;
    end else if (snap.head[4] == CMD_SCOPE && snap.len_ge8[0] && from_radio) begin
      if (snap.head[5] == SUB_SPAN) begin
        s2_nxt.kind = KIND_SPAN;
      end else if (snap.head[5] == SUB_REF) begin
        s2_nxt.kind = KIND_REF;
      end
    end
    for (int i = 0; i < LEAD_PAIRS; i++) begin
      s2_nxt.fpair[i] = bcd_pair(snap.head[5 + i]);
      s2_nxt.lpair[i] = snap.len_ge8[i] ? bcd_pair(snap.head[6 + i]) : '0;
    end
    for (int i = 0; i < TAIL_KEEP; i++) begin
      s2_nxt.tpair[i] = bcd_pair(snap.tail[i]);
    end
    s2_nxt.tbl = snap.len_ge13 ? span_lookup(snap.head[8], snap.head[9]) : '0;
    s2_nxt.tail_ok = snap.len_ge8[2];
    mag = snap.len_ge8[1] ? bcd_pair(snap.head[6]) : '0;
    s2_nxt.ref_level = (snap.len_ge8[1] && snap.head[7][0]) ?
                       -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_comb begin
    s3_nxt.kind = s2_r.kind;
    s3_nxt.f_lo = sum3(s2_r.fpair[0], s2_r.fpair[1], s2_r.fpair[2]);
    s3_nxt.f_hi = sum2(s2_r.fpair[3], s2_r.fpair[4]);
    s3_nxt.t_sum = sum3(s2_r.tpair[2], s2_r.tpair[1], s2_r.tpair[0]);
    s3_nxt.l_lo = sum3(s2_r.lpair[0], s2_r.lpair[1], s2_r.lpair[2]);
    s3_nxt.l_hi = sum2(s2_r.lpair[3], s2_r.lpair[4]);
    s3_nxt.tbl = s2_r.tbl;
    s3_nxt.tail_ok = s2_r.tail_ok;
    s3_nxt.ref_level = s2_r.ref_level;
  end

  always_comb begin
    s4_nxt.kind = s3_r.kind;
    s4_nxt.freq = HZ_W'(s3_r.f_hi) * HZ_W'(1000000) + HZ_W'(s3_r.f_lo);
    s4_nxt.lead = HZ_W'(s3_r.l_hi) * HZ_W'(1000000) + HZ_W'(s3_r.l_lo);
    s4_nxt.t_sum = s3_r.t_sum;
    s4_nxt.tbl = s3_r.tbl;
    s4_nxt.tail_ok = s3_r.tail_ok;
    s4_nxt.ref_level = s3_r.ref_level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (s2_rdy) begin
        s2_vld_r <= snap_valid;
      end
      if (s3_rdy) begin
        s3_vld_r <= s2_vld_r;
      end
      if (s4_rdy) begin
        s4_vld_r <= s3_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && snap_valid) begin
      s2_r <= s2_nxt;
    end
    if (s3_rdy && s2_vld_r) begin
      s3_r <= s3_nxt;
    end
    if (s4_rdy && s3_vld_r) begin
      s4_r <= s4_nxt;
    end
  end

  assign res_valid = s4_vld_r;
  assign res = s4_r;

endmodule

[design/cvfd_update.sv]
// Stored frequency, span and reference level, updated from each decoded frame, and
// the result register that drives the output channel. Depends on cvfd_pkg.
module cvfd_update import cvfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  output logic        res_ready,
  input  res_t        res,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata
);

  logic                    out_vld_r;
  kind_t                   kind_r;
  logic                    chg_r, chg_nxt;
  logic [HZ_W-1:0]         freq_r, freq_nxt;
  logic [HZ_W-1:0]         span_r, span_nxt;
  logic [HZ_W-1:0]         span_sel;
  logic signed [LVL_W-1:0] lvl_r, lvl_nxt;
  logic                    load;

  assign res_ready = !out_vld_r || out_tready;
  assign load = res_valid && res_ready;

  always_comb begin
    freq_nxt = freq_r;
    span_nxt = span_r;
    lvl_nxt = lvl_r;
    chg_nxt = 1'b0;
    if (res.tbl != '0) begin
      span_sel = HZ_W'(res.tbl);
    end else if (res.tail_ok && res.t_sum != '0) begin
      span_sel = HZ_W'(res.t_sum);
    end else begin
      span_sel = res.lead;
    end
    case (res.kind)
      KIND_FREQ: begin
        if (res.freq != '0 && res.freq != freq_r) begin
          freq_nxt = res.freq;
          chg_nxt = 1'b1;
        end
      end
      KIND_SPAN: begin
        if (span_sel != '0 && span_sel != span_r) begin
          span_nxt = span_sel;
          chg_nxt = 1'b1;
        end
      end
      KIND_REF: begin
        if (res.ref_level != lvl_r) begin
          lvl_nxt = res.ref_level;
          chg_nxt = 1'b1;
        end
      end
      default: begin
        chg_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      freq_r <= '0;
      span_r <= SPAN_RST;
      lvl_r <= '0;
    end else begin
      if (load) begin
        out_vld_r <= 1'b1;
        freq_r <= freq_nxt;
        span_r <= span_nxt;
        lvl_r <= lvl_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= res.kind;
      chg_r <= chg_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = {7'd0, chg_r, lvl_r, span_r, freq_r, kind_r};

  a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    span_r != '0)
    else $error("stored span became zero");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r >= -9'sd165 && lvl_r <= 9'sd165)
    else $error("stored reference level out of range");

  a_hold_without_load: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(freq_r) && $stable(span_r) && $stable(lvl_r))
    else $error("stored value changed without a decoded frame");

  a_freq_update: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res.kind == KIND_FREQ && chg_nxt) |=> freq_r != '0 && chg_r)
    else $error("frequency update lost");

endmodule

[design/ci_v_response_frame_decoder_core.sv]
// After the last byte of a frame is transferred, a result reaches out_tvalid through the
// snapshot register, then the classify, partial-sum and full-sum stages and the result register.
// Throughput: one byte per cycle; a frame of one byte may follow another directly.
// The input stalls only when all decode stages hold results the output has not taken.
// Reset (rst_n low, synchronous): byte count and all valids clear, addresses return to
// 0xA4 and 0xE0, stored frequency 0, span 5000 Hz, reference level 0.
module ci_v_response_frame_decoder_core import cvfd_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,   // end_of_frame
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [2:0] frame_kind, [36:3] frequency_hz,
                                  // [70:37] span_hz, [79:71] reference_level,
                                  // [80] value_changed, [87:81] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0] radio_addr;
  logic [7:0] pc_addr;
  logic       snap_valid;
  logic       snap_ready;
  snap_t      snap;
  logic       res_valid;
  logic       res_ready;
  res_t       res;

  cvfd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .radio_addr  (radio_addr),
    .pc_addr     (pc_addr)
  );

  cvfd_capture #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  cvfd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .radio_addr (radio_addr),
    .pc_addr    (pc_addr),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  cvfd_update u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[tb/sv/cvfd_frame_checker.sv]
`timescale 1ns / 1ps
// Frame checker for the CI-V response frame decoder: it follows every byte transfer,
// decodes each frame itself and compares every result transfer field by field.
// Depends on cvfd_pkg for command codes, result kinds, register indexes and reset values.
module cvfd_frame_checker import cvfd_pkg::*; #(
  parameter int MAX_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,   // end_of_frame
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,  // [2:0] frame_kind, [36:3] frequency_hz,
                                  // [70:37] span_hz, [79:71] reference_level,
                                  // [80] value_changed, [87:81] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending,
  output int          frames_checked,
  output int          updates_seen
);

  localparam int TAIL_BYTES = 4;

  typedef struct packed {
    kind_t                   kind;
    logic [HZ_W-1:0]         freq_hz;
    logic [HZ_W-1:0]         span_hz;
    logic signed [LVL_W-1:0] level;
    logic                    changed;
  } frame_report_t;

  logic [7:0]              radio_addr;
  logic [7:0]              pc_addr;
  int unsigned             nbytes;
  logic [7:0]              head [HEAD_DEPTH];
  logic [7:0]              tail [TAIL_BYTES];
  logic [HZ_W:0]           freq_now;
  logic [HZ_W:0]           span_now;
  logic signed [LVL_W-1:0] level_now;
  frame_report_t           decodes_due [$];

  task automatic flag_mismatch(input string msg);
    $display("%s", msg);
    fail_count++;
  endtask

  function automatic longint unsigned pair_value(input logic [7:0] b);
    return longint'(b[7:4]) * 10 + longint'(b[3:0]);
  endfunction

  // Byte pairs from head[first] upward, lowest pair first.
  function automatic longint unsigned bcd_run(input int first, input int count);
    longint unsigned sum;
    longint unsigned weight;
    int i;
    sum = 0;
    weight = 1;
    for (i = 0; i < count; i++) begin
      sum += pair_value(head[first + i]) * weight;
      weight *= 100;
    end
    return sum;
  endfunction

  function automatic longint unsigned fixed_span(input logic [7:0] lo, input logic [7:0] hi);
    case ({hi, lo})
      16'h0025: return 2500;
      16'h0050: return 5000;
      16'h0100: return 10000;
      16'h0250: return 25000;
      16'h0500: return 50000;
      16'h1000: return 100000;
      16'h2500: return 250000;
      16'h5000: return 500000;
      default:  return 0;
    endcase
  endfunction

  function automatic longint unsigned coded_span(input logic [15:0] code);
    case (code)
      16'd2: return 2500;
      16'd5, 16'd10, 16'd25, 16'd50, 16'd100, 16'd250, 16'd500: return longint'(code) * 1000;
      default: return 0;
    endcase
  endfunction

  function automatic longint unsigned span_from_payload();
    int unsigned plen;
    longint unsigned hz;
    plen = nbytes - 7;
    hz = 0;
    if (plen >= 6) begin
      hz = fixed_span(head[8], head[9]);
      if (hz == 0) hz = coded_span({head[9], head[8]});
    end
    if (hz == 0 && plen >= 3)
      hz = longint'(tail[0][7:4]) * 100000 + longint'(tail[0][3:0]) * 10000 +
           longint'(tail[1][7:4]) * 1000 + longint'(tail[1][3:0]) * 100 +
           longint'(tail[2][7:4]) * 10 + longint'(tail[2][3:0]);
    if (hz == 0) hz = bcd_run(6, plen < 5 ? plen : 5);
    return hz;
  endfunction

  task automatic decode_frame(output frame_report_t r);
    logic from_radio;
    longint unsigned hz;
    int lvl;
    logic signed [LVL_W-1:0] lvl9;
    r.kind = KIND_IGNORE;
    r.changed = 1'b0;
    if (nbytes >= 5) begin
      from_radio = (head[2] == pc_addr) && (head[3] == radio_addr);
      if (head[4] == CMD_ACK) begin
        r.kind = KIND_ACK;
      end else if (head[4] == CMD_NG) begin
        r.kind = KIND_NG;
      end else if (head[4] == CMD_FREQ && nbytes >= 11 && from_radio) begin
        r.kind = KIND_FREQ;
        hz = bcd_run(5, 5);
        if (hz != 0 && (HZ_W + 1)'(hz) != freq_now) begin
          freq_now = (HZ_W + 1)'(hz);
          r.changed = 1'b1;
        end
      end else if (head[4] == CMD_SCOPE && nbytes >= 8 && from_radio) begin
        if (head[5] == SUB_SPAN) begin
          r.kind = KIND_SPAN;
          hz = span_from_payload();
          if (hz != 0 && (HZ_W + 1)'(hz) != span_now) begin
            span_now = (HZ_W + 1)'(hz);
            r.changed = 1'b1;
          end
        end else if (head[5] == SUB_REF) begin
          lvl = 0;
          if (nbytes >= 9) begin
            lvl = int'(pair_value(head[6]));
            if (head[7][0]) lvl = -lvl;
          end
          lvl9 = LVL_W'(lvl);
          r.kind = KIND_REF;
          if (lvl9 != level_now) begin
            level_now = lvl9;
            r.changed = 1'b1;
          end
        end
      end
    end
    r.freq_hz = freq_now[HZ_W-1:0];
    r.span_hz = span_now[HZ_W-1:0];
    r.level = level_now;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    frame_report_t r;
    int i;
    if (nbytes < HEAD_DEPTH) head[nbytes] = b;
    for (i = 0; i < TAIL_BYTES - 1; i++) tail[i] = tail[i + 1];
    tail[TAIL_BYTES - 1] = b;
    if (nbytes < MAX_BYTES) nbytes++;
    if (last) begin
      decode_frame(r);
      decodes_due.push_back(r);
      nbytes = 0;
    end
  endtask

  task automatic check_result(input logic [87:0] d);
    frame_report_t want;
    if (decodes_due.size() == 0) begin
      flag_mismatch($sformatf("Result transfer with no frame waiting: data %h.", d));
      return;
    end
    want = decodes_due.pop_front();
    frames_checked++;
    if (d[80]) updates_seen++;
    if (d[2:0] != want.kind)
      flag_mismatch($sformatf("Frame %0d kind: got %0d, expected %0d.",
                              frames_checked, d[2:0], want.kind));
    if (d[36:3] != want.freq_hz)
      flag_mismatch($sformatf("Frame %0d frequency: got %0d, expected %0d.",
                              frames_checked, d[36:3], want.freq_hz));
    if (d[70:37] != want.span_hz)
      flag_mismatch($sformatf("Frame %0d span: got %0d, expected %0d.",
                              frames_checked, d[70:37], want.span_hz));
    if (d[79:71] != want.level)
      flag_mismatch($sformatf("Frame %0d reference level: got %0d, expected %0d.",
                              frames_checked, $signed(d[79:71]), want.level));
    if (d[80] != want.changed)
      flag_mismatch($sformatf("Frame %0d changed flag: got %0d, expected %0d.",
                              frames_checked, d[80], want.changed));
  endtask

  task automatic clear_model();
    int i;
    radio_addr = RADIO_ADDR_RST;
    pc_addr = PC_ADDR_RST;
    nbytes = 0;
    for (i = 0; i < HEAD_DEPTH; i++) head[i] = 8'h00;
    for (i = 0; i < TAIL_BYTES; i++) tail[i] = 8'h00;
    freq_now = '0;
    span_now = (HZ_W + 1)'(SPAN_RST);
    level_now = '0;
    decodes_due.delete();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_RADIO_ADDR) radio_addr = cfg_pwdata[7:0];
        else if (cfg_paddr[2] == REG_PC_ADDR) pc_addr = cfg_pwdata[7:0];
      end
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result(out_tdata);
    end
    pending = decodes_due.size();
  end

endmodule

[tb/sv/tb_ci_v_response_frame_decoder_core.sv]
`timescale 1ns / 1ps
// Top of the CI-V response frame decoder testbench: clock, reset, frame stimulus,
// register writes, output stalls and the verdict. Needs cvfd_pkg, the decoder core
// and cvfd_frame_checker, which does all prediction and comparison.
module tb_ci_v_response_frame_decoder_core;
  import cvfd_pkg::*;

  localparam int FRAME_LIMIT = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_BYTES = 270;
  localparam int LONG_FRAME_BYTES = 80;
  localparam logic [7:0] PREAMBLE = 8'hFE;
  localparam logic [7:0] END_MARK = 8'hFD;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending;
  int frames_checked;
  int updates_seen;

  int cycle_count = 0;
  int bytes_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  logic [7:0] radio_now = RADIO_ADDR_RST;
  logic [7:0] pc_now = PC_ADDR_RST;
  logic [7:0] frame_bytes [$];
  logic [7:0] last_freq [5];

  ci_v_response_frame_decoder_core #(.MAX_FRAME_BYTES(FRAME_LIMIT)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  cvfd_frame_checker #(.MAX_BYTES(FRAME_LIMIT)) decode_watch (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .pending(pending), .frames_checked(frames_checked),
    .updates_seen(updates_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // A requested hold keeps the result side stalled.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_asked != holds_done) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else begin
        out_tready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 20) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      in_tdata = 8'($urandom);
      in_tlast = 1'($urandom_range(1));
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = b;
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_bytes.size(); i++) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
  endtask

  task automatic put(input logic [7:0] b);
    frame_bytes.push_back(b);
  endtask

  task automatic hdr(input logic [7:0] dst, input logic [7:0] src, input logic [7:0] cmd);
    frame_bytes.delete();
    put(PREAMBLE);
    put(PREAMBLE);
    put(dst);
    put(src);
    put(cmd);
  endtask

  task automatic finish_frame();
    put(END_MARK);
    send_frame();
  endtask

  function automatic logic [7:0] bcd_byte();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'($urandom);
    if (r < 15) return 8'h00;
    return {4'($urandom_range(9)), 4'($urandom_range(9))};
  endfunction

  function automatic logic [15:0] span_code_word(input int idx);
    case (idx)
      0:  return 16'h0025;
      1:  return 16'h0050;
      2:  return 16'h0100;
      3:  return 16'h0250;
      4:  return 16'h0500;
      5:  return 16'h1000;
      6:  return 16'h2500;
      7:  return 16'h5000;
      8:  return 16'd2;
      9:  return 16'd5;
      10: return 16'd10;
      11: return 16'd25;
      12: return 16'd50;
      13: return 16'd100;
      14: return 16'd250;
      15: return 16'd500;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_random_frame();
    int pick;
    int count;
    int mode;
    int i;
    logic [7:0] dst;
    logic [7:0] src;
    logic [7:0] b;
    logic [15:0] code;
    pick = $urandom_range(99);
    dst = pc_now;
    src = radio_now;
    if ($urandom_range(99) < 12) begin
      if ($urandom_range(1) == 1) dst = dst ^ (8'd1 << $urandom_range(7));
      else src = src ^ (8'd1 << $urandom_range(7));
    end
    if (pick < 20) begin
      hdr(dst, src, CMD_FREQ);
      if ($urandom_range(9) == 0) begin
        for (i = 0; i < 5; i++) put(last_freq[i]);
      end else begin
        for (i = 0; i < 5; i++) begin
          last_freq[i] = bcd_byte();
          put(last_freq[i]);
        end
      end
    end else if (pick < 45) begin
      hdr(dst, src, CMD_SCOPE);
      put(SUB_SPAN);
      count = $urandom_range(1, 10);
      code = span_code_word($urandom_range(16));
      mode = $urandom_range(3);
      for (i = 0; i < count; i++) begin
        case (mode)
          0, 1: b = bcd_byte();
          2: b = (i == count - 1 && $urandom_range(1) == 1) ? bcd_byte() : 8'h00;
          default: b = 8'($urandom);
        endcase
        if (mode == 0 && i == 2) b = code[7:0];
        if (mode == 0 && i == 3) b = code[15:8];
        put(b);
      end
    end else if (pick < 60) begin
      hdr(dst, src, CMD_SCOPE);
      put(SUB_REF);
      count = $urandom_range(3);
      if (count >= 1) put($urandom_range(3) == 0 ? 8'($urandom) : bcd_byte());
      if (count >= 2) put(8'($urandom));
      if (count >= 3) put(8'($urandom));
    end else if (pick < 70) begin
      hdr($urandom_range(3) == 0 ? 8'($urandom) : dst, $urandom_range(3) == 0 ? 8'($urandom) : src,
          $urandom_range(1) == 1 ? CMD_ACK : CMD_NG);
      repeat ($urandom_range(2)) put(8'($urandom));
    end else if (pick < 80) begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 4)) put(8'($urandom));
      send_frame();
      return;
    end else begin
      hdr(dst, src, $urandom_range(2) == 0 ? CMD_SCOPE : 8'($urandom));
      repeat ($urandom_range(10)) put(8'($urandom));
    end
    if ($urandom_range(19) == 0 && frame_bytes.size() > 6) void'(frame_bytes.pop_back());
    finish_frame();
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = {24'h0, value};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    if (idx == REG_RADIO_ADDR) radio_now = value;
    else pc_now = value;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    in_tlast = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input logic hold);
    int target;
    idle_pct = idle;
    stall_pct = stall;
    if (hold) holds_asked++;
    target = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) add_random_frame();
    wait_idle();
  endtask

  task automatic run_directed();
    hdr(pc_now, radio_now, CMD_ACK);
    finish_frame();
    hdr(8'h00, 8'hFF, CMD_NG);
    finish_frame();
    hdr(pc_now, radio_now, CMD_FREQ);
    repeat (5) put(8'h00);
    finish_frame();
    hdr(pc_now, radio_now, CMD_FREQ);
    repeat (5) put(8'h99);
    finish_frame();
    repeat (2) begin
      hdr(pc_now, radio_now, CMD_FREQ);
      repeat (5) put(8'hFF);
      finish_frame();
    end
    hdr(pc_now, ~radio_now, CMD_FREQ);
    repeat (5) put(8'h12);
    finish_frame();
    hdr(pc_now, radio_now, CMD_FREQ);
    repeat (4) put(8'h34);
    finish_frame();
    hdr(pc_now, radio_now, CMD_SCOPE);
    put(SUB_SPAN);
    put(8'h00); put(8'h00); put(8'h50); put(8'h02); put(8'h00); put(8'h00);
    finish_frame();
    hdr(pc_now, radio_now, CMD_SCOPE);
    put(SUB_SPAN);
    put(8'h00); put(8'h00); put(8'hF4); put(8'h01); put(8'h00); put(8'h00);
    finish_frame();
    hdr(pc_now, radio_now, CMD_SCOPE);
    put(SUB_SPAN);
    put(8'h00); put(8'h12); put(8'h34); put(8'h56);
    finish_frame();
    hdr(pc_now, radio_now, CMD_SCOPE);
    put(SUB_SPAN);
    put(8'h50);
    finish_frame();
    hdr(pc_now, radio_now, CMD_SCOPE);
    put(SUB_SPAN);
    put(8'h00); put(8'h00);
    finish_frame();
    hdr(~pc_now, radio_now, CMD_SCOPE);
    put(SUB_SPAN);
    put(8'h25);
    finish_frame();
    hdr(pc_now, radio_now, CMD_SCOPE);
    put(SUB_REF);
    finish_frame();
    hdr(pc_now, radio_now, CMD_SCOPE);
    put(SUB_REF);
    put(8'h55);
    finish_frame();
    hdr(pc_now, radio_now, CMD_SCOPE);
    put(SUB_REF);
    put(8'h99); put(8'h00);
    finish_frame();
    hdr(pc_now, radio_now, CMD_SCOPE);
    put(SUB_REF);
    put(8'hFF); put(8'h01);
    finish_frame();
    hdr(pc_now, radio_now, CMD_SCOPE);
    put(SUB_REF);
    put(8'h00); put(8'hFE);
    finish_frame();
    hdr(pc_now, radio_now, CMD_SCOPE);
    put(8'h11);
    finish_frame();
    frame_bytes.delete();
    put(PREAMBLE);
    send_frame();
    frame_bytes.delete();
    put(PREAMBLE); put(PREAMBLE); put(pc_now); put(radio_now);
    send_frame();
  endtask

  initial begin
    int i;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    rst_n = 1'b0;
    for (i = 0; i < 5; i++) last_freq[i] = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    wait_idle();

    // Frames longer than the byte counter's limit of FRAME_LIMIT bytes.
    hdr(pc_now, radio_now, CMD_FREQ);
    repeat (LONG_FRAME_BYTES) put(bcd_byte());
    finish_frame();
    hdr(pc_now, radio_now, CMD_SCOPE);
    put(SUB_SPAN);
    repeat (LONG_FRAME_BYTES) put(8'($urandom));
    finish_frame();
    run_phase(0, 0, 1'b0);

    write_reg(REG_RADIO_ADDR, 8'h00);
    write_reg(REG_PC_ADDR, 8'hFF);
    run_phase(62, 0, 1'b0);
    write_reg(REG_RADIO_ADDR, 8'hFF);
    write_reg(REG_PC_ADDR, 8'h00);
    run_phase(0, 62, 1'b0);
    write_reg(REG_RADIO_ADDR, 8'($urandom));
    write_reg(REG_PC_ADDR, 8'($urandom));
    run_phase(28, 28, 1'b0);
    write_reg(REG_RADIO_ADDR, RADIO_ADDR_RST);
    write_reg(REG_PC_ADDR, PC_ADDR_RST);
    run_phase(0, 0, 1'b1);
    write_reg(REG_RADIO_ADDR, 8'($urandom));
    write_reg(REG_PC_ADDR, 8'($urandom));
    run_phase(28, 28, 1'b0);

    $display("Checked %0d decoded frames from %0d byte transfers; %0d updated a stored value.",
             frames_checked, bytes_sent, updates_seen);
    $display("Covered over-long frames, address settings 0x00 to 0xFF, idle gaps, a long output hold.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
